@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl of the record parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define FCRPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define FCRPP_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/fcrpp_pkg.sv @@
// types and constants of the fastcgi record parameter parser
`default_nettype none

package fcrpp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CONTENT,
    PH_PADDING,
    PH_CLOSED
  } stream_phase_e;

  typedef enum logic [2:0] {
    PP_NLEN,
    PP_VLEN,
    PP_NAME,
    PP_VALUE,
    PP_IGNORE,
    PP_BEGIN
  } pair_phase_e;

  localparam logic [7:0] KIND_BEGIN  = 8'd1;
  localparam logic [7:0] KIND_ABORT  = 8'd2;
  localparam logic [7:0] KIND_PARAMS = 8'd4;
  localparam logic [7:0] KIND_STDIN  = 8'd5;

  localparam logic [2:0] CLS_HEADER = 3'd0;
  localparam logic [2:0] CLS_BEGIN  = 3'd1;
  localparam logic [2:0] CLS_LENGTH = 3'd2;
  localparam logic [2:0] CLS_NAME   = 3'd3;
  localparam logic [2:0] CLS_VALUE  = 3'd4;
  localparam logic [2:0] CLS_IGNORE = 3'd5;
  localparam logic [2:0] CLS_PAD    = 3'd6;
  localparam logic [2:0] CLS_CLOSED = 3'd7;

  localparam logic [3:0] EV_NONE       = 4'd0;
  localparam logic [3:0] EV_BEGIN_OK   = 4'd1;
  localparam logic [3:0] EV_BEGIN_IGN  = 4'd2;
  localparam logic [3:0] EV_PARAMS_END = 4'd3;
  localparam logic [3:0] EV_END_REC    = 4'd4;
  localparam logic [3:0] EV_ABORT      = 4'd5;
  localparam logic [3:0] EV_PAIR_START = 4'd6;
  localparam logic [3:0] EV_PAIR_DROP  = 4'd7;
  localparam logic [3:0] EV_PARAMS_IGN = 4'd8;
  localparam logic [3:0] EV_UNKNOWN    = 4'd9;

  localparam logic [2:0] HDR_LAST_IDX = 3'd7;
  localparam logic [15:0] BEGIN_BODY_LEN = 16'd8;
  localparam logic [15:0] LONG_LEN_MIN = 16'd4;

  typedef struct packed {
    logic        bad_version;
    logic        record_last;
    logic [15:0] pair_index;
    logic [30:0] value_length;
    logic [30:0] name_length;
    logic [3:0]  event_code;
    logic [15:0] record_id;
    logic [7:0]  record_kind;
    logic [2:0]  byte_class;
    logic [7:0]  byte_value;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/fastcgi_record_param_parser_unit.sv @@
// top level of the fastcgi record parameter parser
`default_nettype none
`include "assert_macros.svh"

// Parses a FastCGI connection stream one byte per request and gives one registered result
// per byte. A byte is taken in every cycle while the skid entry is empty: the per-byte
// update of the header, content and pair-length state is a single registered step, and an
// output register with one skid entry keeps the input side moving while a result waits
// downstream. Once an abort record has ended, every later byte is classed as after close.
module fastcgi_record_param_parser_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output      logic         s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // stream_byte
  output      logic         m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // byte_value, record_kind, record_id, event_code, name_length, value_length,
  // pair_index, bad_version, zero fill
  output      logic [119:0] m_axis_tdata_o,
  output      logic [2:0]   m_axis_tuser_o,   // byte_class
  output      logic         m_axis_tlast_o    // record_last
);
  import fcrpp_pkg::*;

  logic [2:0]    header_index_q, header_index_d;
  stream_phase_e stream_phase_q, stream_phase_d;
  logic [7:0]    hdr_version_q, hdr_version_d;
  logic [7:0]    hdr_kind_q, hdr_kind_d;
  logic [15:0]   hdr_id_q, hdr_id_d;
  logic [15:0]   content_q, content_d;
  logic [7:0]    padding_q, padding_d;
  pair_phase_e   pair_phase_q, pair_phase_d;
  logic [30:0]   length_accum_q, length_accum_d;
  logic [1:0]    length_bytes_seen_q, length_bytes_seen_d;
  logic [30:0]   name_len_q, name_len_d;
  logic [30:0]   value_len_q, value_len_d;
  logic          request_begun_q, request_begun_d;
  logic [15:0]   active_id_q, active_id_d;
  logic [15:0]   pair_counter_q, pair_counter_d;

  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    accept, pop;

  logic [7:0]  b;
  logic [2:0]  cls;
  logic [3:0]  ev;
  logic        last;
  logic [15:0] rem;
  logic        done;
  logic [30:0] len_val;
  logic [30:0] shifted;
  logic [30:0] dec;
  logic [31:0] pair_sum;

  assign b       = s_axis_tdata_i;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign pop     = out_valid_q && m_axis_tready_i;
  assign rem     = (content_q != 16'd0) ? content_q - 16'd1 : 16'd0;
  assign shifted = {length_accum_q[22:0], b};
  assign dec     = (length_accum_q != 31'd0) ? length_accum_q - 31'd1 : length_accum_q;

  always_comb begin
    header_index_d      = header_index_q;
    stream_phase_d      = stream_phase_q;
    hdr_version_d       = hdr_version_q;
    hdr_kind_d          = hdr_kind_q;
    hdr_id_d            = hdr_id_q;
    content_d           = content_q;
    padding_d           = padding_q;
    pair_phase_d        = pair_phase_q;
    length_accum_d      = length_accum_q;
    length_bytes_seen_d = length_bytes_seen_q;
    name_len_d          = name_len_q;
    value_len_d         = value_len_q;
    request_begun_d     = request_begun_q;
    active_id_d         = active_id_q;
    pair_counter_d      = pair_counter_q;
    cls                 = CLS_HEADER;
    ev                  = EV_NONE;
    last                = 1'b0;
    done                = 1'b0;
    len_val             = 31'd0;
    pair_sum            = 32'd0;

    case (stream_phase_q)
      PH_HEADER: begin
        case (header_index_q)
          3'd0: begin
            hdr_version_d = b;
            hdr_kind_d    = 8'd0;
            hdr_id_d      = 16'd0;
            content_d     = 16'd0;
            padding_d     = 8'd0;
          end
          3'd1: hdr_kind_d = b;
          3'd2: hdr_id_d = {b, 8'd0};
          3'd3: hdr_id_d = {hdr_id_q[15:8], b};
          3'd4: content_d = {b, 8'd0};
          3'd5: content_d = {content_q[15:8], b};
          3'd6: padding_d = b;
          default: ;
        endcase
        if (header_index_q == HDR_LAST_IDX) begin
          header_index_d      = 3'd0;
          pair_phase_d        = PP_IGNORE;
          length_bytes_seen_d = 2'd0;
          if (hdr_kind_q == KIND_BEGIN) begin
            if (!request_begun_q && content_q == BEGIN_BODY_LEN) begin
              request_begun_d = 1'b1;
              active_id_d     = hdr_id_q;
              pair_counter_d  = 16'd0;
              pair_phase_d    = PP_BEGIN;
              ev              = EV_BEGIN_OK;
            end else begin
              ev = EV_BEGIN_IGN;
            end
          end else if (hdr_kind_q == KIND_PARAMS) begin
            if (!request_begun_q || active_id_q != hdr_id_q) begin
              ev = EV_PARAMS_IGN;
            end else if (content_q == 16'd0) begin
              ev = EV_PARAMS_END;
            end else begin
              pair_phase_d = PP_NLEN;
            end
          end else if (hdr_kind_q == KIND_STDIN) begin
            ev = EV_END_REC;
          end else if (hdr_kind_q == KIND_ABORT) begin
            ev = EV_ABORT;
          end else begin
            ev = EV_UNKNOWN;
          end
          if (content_q != 16'd0) begin
            stream_phase_d = PH_CONTENT;
          end else if (padding_q != 8'd0) begin
            stream_phase_d = PH_PADDING;
          end else begin
            last = 1'b1;
          end
        end else begin
          header_index_d = header_index_q + 3'd1;
        end
      end
      PH_CONTENT: begin
        content_d = rem;
        case (pair_phase_q)
          PP_NLEN, PP_VLEN: begin
            cls = CLS_LENGTH;
            if (length_bytes_seen_q == 2'd0) begin
              if (pair_phase_q == PP_NLEN) begin
                name_len_d  = 31'd0;
                value_len_d = 31'd0;
              end
              if (!b[7]) begin
                len_val = {23'd0, b};
                done    = 1'b1;
              end else if (content_q < LONG_LEN_MIN) begin
                cls          = CLS_IGNORE;
                ev           = EV_PAIR_DROP;
                pair_phase_d = PP_IGNORE;
              end else begin
                length_accum_d      = {24'd0, b[6:0]};
                length_bytes_seen_d = 2'd1;
              end
            end else begin
              length_accum_d = shifted;
              if (length_bytes_seen_q == 2'd3) begin
                length_bytes_seen_d = 2'd0;
                len_val             = shifted;
                done                = 1'b1;
              end else begin
                length_bytes_seen_d = length_bytes_seen_q + 2'd1;
              end
            end
            if (done) begin
              if (pair_phase_q == PP_NLEN) begin
                name_len_d = len_val;
                if (rem == 16'd0) begin
                  ev           = EV_PAIR_DROP;
                  pair_phase_d = PP_IGNORE;
                end else begin
                  pair_phase_d = PP_VLEN;
                end
              end else begin
                value_len_d = len_val;
                pair_sum    = {1'b0, name_len_q} + {1'b0, len_val};
                if ({16'd0, rem} < pair_sum) begin
                  ev           = EV_PAIR_DROP;
                  pair_phase_d = PP_IGNORE;
                end else begin
                  ev = EV_PAIR_START;
                  if (pair_counter_q != 16'hffff) begin
                    pair_counter_d = pair_counter_q + 16'd1;
                  end
                  if (name_len_q != 31'd0) begin
                    pair_phase_d   = PP_NAME;
                    length_accum_d = name_len_q;
                  end else if (len_val != 31'd0) begin
                    pair_phase_d   = PP_VALUE;
                    length_accum_d = len_val;
                  end else begin
                    pair_phase_d = PP_NLEN;
                  end
                end
              end
            end
          end
          PP_NAME: begin
            cls            = CLS_NAME;
            length_accum_d = dec;
            if (dec == 31'd0) begin
              if (value_len_q != 31'd0) begin
                pair_phase_d   = PP_VALUE;
                length_accum_d = value_len_q;
              end else begin
                pair_phase_d = PP_NLEN;
              end
            end
          end
          PP_VALUE: begin
            cls            = CLS_VALUE;
            length_accum_d = dec;
            if (dec == 31'd0) begin
              pair_phase_d = PP_NLEN;
            end
          end
          PP_BEGIN: cls = CLS_BEGIN;
          default:  cls = CLS_IGNORE;
        endcase
        if (rem == 16'd0) begin
          if (padding_q != 8'd0) begin
            stream_phase_d = PH_PADDING;
          end else begin
            last = 1'b1;
          end
        end
      end
      PH_PADDING: begin
        cls = CLS_PAD;
        if (padding_q != 8'd0) begin
          padding_d = padding_q - 8'd1;
        end
        if (padding_d == 8'd0) begin
          last = 1'b1;
        end
      end
      default: begin
        cls = CLS_CLOSED;
      end
    endcase

    if (last) begin
      stream_phase_d = PH_HEADER;
      header_index_d = 3'd0;
      if (hdr_kind_d == KIND_ABORT) begin
        stream_phase_d = PH_CLOSED;
      end
    end
  end

  always_comb begin
    res.byte_value = b;
    res.byte_class = cls;
    if (stream_phase_q == PH_CLOSED) begin
      res.record_kind  = 8'd0;
      res.record_id    = 16'd0;
      res.event_code   = EV_NONE;
      res.name_length  = 31'd0;
      res.value_length = 31'd0;
      res.pair_index   = 16'd0;
      res.bad_version  = 1'b0;
      res.record_last  = 1'b0;
    end else begin
      res.record_kind  = hdr_kind_d;
      res.record_id    = hdr_id_d;
      res.event_code   = ev;
      res.name_length  = name_len_d;
      res.value_length = value_len_d;
      res.pair_index   = pair_counter_d;
      res.bad_version  = (hdr_version_d != 8'd1);
      res.record_last  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_index_q      <= 3'd0;
      stream_phase_q      <= PH_HEADER;
      hdr_version_q       <= 8'd0;
      hdr_kind_q          <= 8'd0;
      hdr_id_q            <= 16'd0;
      content_q           <= 16'd0;
      padding_q           <= 8'd0;
      pair_phase_q        <= PP_NLEN;
      length_accum_q      <= 31'd0;
      length_bytes_seen_q <= 2'd0;
      name_len_q          <= 31'd0;
      value_len_q         <= 31'd0;
      request_begun_q     <= 1'b0;
      active_id_q         <= 16'd0;
      pair_counter_q      <= 16'd0;
    end else if (accept) begin
      header_index_q      <= header_index_d;
      stream_phase_q      <= stream_phase_d;
      hdr_version_q       <= hdr_version_d;
      hdr_kind_q          <= hdr_kind_d;
      hdr_id_q            <= hdr_id_d;
      content_q           <= content_d;
      padding_q           <= padding_d;
      pair_phase_q        <= pair_phase_d;
      length_accum_q      <= length_accum_d;
      length_bytes_seen_q <= length_bytes_seen_d;
      name_len_q          <= name_len_d;
      value_len_q         <= value_len_d;
      request_begun_q     <= request_begun_d;
      active_id_q         <= active_id_d;
      pair_counter_q      <= pair_counter_d;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.byte_class;
  assign m_axis_tlast_o  = out_q.record_last;
  assign m_axis_tdata_o  = {5'd0, out_q.bad_version, out_q.pair_index, out_q.value_length,
                            out_q.name_length, out_q.event_code, out_q.record_id,
                            out_q.record_kind, out_q.byte_value};

  `FCRPP_ASSERT_ANY(a_reset_empties, !rst_ni |=> (!out_valid_q && !skid_valid_q),
    "output not empty after reset")
  `FCRPP_ASSERT(a_skid_needs_out, !skid_valid_q || out_valid_q, "skid entry without output")
  `FCRPP_ASSERT(a_closed_stays, stream_phase_q == PH_CLOSED |=> stream_phase_q == PH_CLOSED,
    "closed connection reopened")
  `FCRPP_ASSERT(a_body_count_live,
    (pair_phase_q == PP_NAME || pair_phase_q == PP_VALUE) |-> length_accum_q != 31'd0,
    "name or value phase with nothing left")
  `FCRPP_ASSERT(a_long_len_phase,
    length_bytes_seen_q != 2'd0 |-> (pair_phase_q == PP_NLEN || pair_phase_q == PP_VLEN),
    "long length in progress outside a length phase")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// self-checking bench for the fastcgi record parameter parser, byte stream in, per-byte verdict out
`timescale 1ns / 1ps

module tb;
  import fcrpp_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 400;
  localparam int RANDOM_BYTES = 380;
  localparam logic [7:0] VERSION_1 = 8'd1;
  localparam logic [7:0] UNKNOWN_KIND = 8'd3;
  localparam logic [15:0] SESSION_ID = 16'hbeef;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [7:0] s_data = 8'd0;
  logic m_ready = 1'b0;
  wire s_ready;
  wire m_valid;
  wire [119:0] m_data;
  wire [2:0] m_user;
  wire m_last;

  always #5 clk_i = ~clk_i;

  fastcgi_record_param_parser_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  logic [7:0] stream_bytes[$];
  logic [7:0] body[$];
  result_t parse_results[$];
  int sent_count = 0;
  int rx_count = 0;
  int calm_from = 0;
  int fail_count = 0;
  int send_gap = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int idle_cycles = 0;

  // parser state mirror
  logic [2:0] hdr_pos = 3'd0;
  stream_phase_e sphase = PH_HEADER;
  logic [7:0] ver = 8'd0;
  logic [7:0] kind = 8'd0;
  logic [15:0] rec_id = 16'd0;
  logic [15:0] content_left = 16'd0;
  logic [7:0] pad_left = 8'd0;
  pair_phase_e pphase = PP_NLEN;
  logic [31:0] len_acc = 32'd0;
  logic [1:0] len_cnt = 2'd0;
  logic [30:0] nlen = 31'd0;
  logic [30:0] vlen = 31'd0;
  logic req_open = 1'b0;
  logic [15:0] req_id = 16'd0;
  logic [15:0] pairs = 16'd0;
  logic closed = 1'b0;

  function automatic result_t parse_stream_byte(input logic [7:0] b);
    result_t r;
    logic [2:0] cls;
    logic [3:0] ev;
    logic last;
    logic [15:0] avail;
    logic [15:0] rem;
    logic done;
    logic [30:0] val;
    r = '0;
    cls = CLS_HEADER;
    ev = EV_NONE;
    last = 1'b0;
    if (closed) begin
      r.byte_value = b;
      r.byte_class = CLS_CLOSED;
      return r;
    end
    if (sphase == PH_HEADER) begin
      case (hdr_pos)
        3'd0: begin
          ver = b;
          kind = 8'd0;
          rec_id = 16'd0;
          content_left = 16'd0;
          pad_left = 8'd0;
        end
        3'd1: kind = b;
        3'd2: rec_id = {b, 8'd0};
        3'd3: rec_id = rec_id | {8'd0, b};
        3'd4: content_left = {b, 8'd0};
        3'd5: content_left = content_left | {8'd0, b};
        3'd6: pad_left = b;
        default: ;
      endcase
      if (hdr_pos == HDR_LAST_IDX) begin
        hdr_pos = 3'd0;
        pphase = PP_IGNORE;
        len_cnt = 2'd0;
        if (kind == KIND_BEGIN) begin
          if (!req_open && content_left == BEGIN_BODY_LEN) begin
            req_open = 1'b1;
            req_id = rec_id;
            pairs = 16'd0;
            pphase = PP_BEGIN;
            ev = EV_BEGIN_OK;
          end else begin
            ev = EV_BEGIN_IGN;
          end
        end else if (kind == KIND_PARAMS) begin
          if (!req_open || req_id != rec_id) begin
            ev = EV_PARAMS_IGN;
          end else if (content_left == 16'd0) begin
            ev = EV_PARAMS_END;
          end else begin
            pphase = PP_NLEN;
          end
        end else if (kind == KIND_STDIN) begin
          ev = EV_END_REC;
        end else if (kind == KIND_ABORT) begin
          ev = EV_ABORT;
        end else begin
          ev = EV_UNKNOWN;
        end
        if (content_left != 16'd0) sphase = PH_CONTENT;
        else if (pad_left != 8'd0) sphase = PH_PADDING;
        else last = 1'b1;
      end else begin
        hdr_pos = hdr_pos + 3'd1;
      end
    end else if (sphase == PH_CONTENT) begin
      avail = content_left;
      rem = (avail != 16'd0) ? avail - 16'd1 : 16'd0;
      content_left = rem;
      case (pphase)
        PP_NLEN, PP_VLEN: begin
          done = 1'b0;
          val = 31'd0;
          cls = CLS_LENGTH;
          if (len_cnt == 2'd0) begin
            if (pphase == PP_NLEN) begin
              nlen = 31'd0;
              vlen = 31'd0;
            end
            if (!b[7]) begin
              val = {23'd0, b};
              done = 1'b1;
            end else if (avail < LONG_LEN_MIN) begin
              cls = CLS_IGNORE;
              ev = EV_PAIR_DROP;
              pphase = PP_IGNORE;
            end else begin
              len_acc = {25'd0, b[6:0]};
              len_cnt = 2'd1;
            end
          end else begin
            len_acc = {1'b0, len_acc[22:0], b};
            if (len_cnt == 2'd3) begin
              len_cnt = 2'd0;
              val = len_acc[30:0];
              done = 1'b1;
            end else begin
              len_cnt = len_cnt + 2'd1;
            end
          end
          if (done) begin
            if (pphase == PP_NLEN) begin
              nlen = val;
              if (rem == 16'd0) begin
                ev = EV_PAIR_DROP;
                pphase = PP_IGNORE;
              end else begin
                pphase = PP_VLEN;
              end
            end else begin
              vlen = val;
              if ({17'd0, rem} < ({2'b00, nlen} + {2'b00, vlen})) begin
                ev = EV_PAIR_DROP;
                pphase = PP_IGNORE;
              end else begin
                ev = EV_PAIR_START;
                if (pairs != 16'hffff) pairs = pairs + 16'd1;
                if (nlen != 31'd0) begin
                  pphase = PP_NAME;
                  len_acc = {1'b0, nlen};
                end else if (vlen != 31'd0) begin
                  pphase = PP_VALUE;
                  len_acc = {1'b0, vlen};
                end else begin
                  pphase = PP_NLEN;
                end
              end
            end
          end
        end
        PP_NAME: begin
          cls = CLS_NAME;
          if (len_acc != 32'd0) len_acc = len_acc - 32'd1;
          if (len_acc == 32'd0) begin
            if (vlen != 31'd0) begin
              pphase = PP_VALUE;
              len_acc = {1'b0, vlen};
            end else begin
              pphase = PP_NLEN;
            end
          end
        end
        PP_VALUE: begin
          cls = CLS_VALUE;
          if (len_acc != 32'd0) len_acc = len_acc - 32'd1;
          if (len_acc == 32'd0) pphase = PP_NLEN;
        end
        PP_BEGIN: cls = CLS_BEGIN;
        default: cls = CLS_IGNORE;
      endcase
      if (rem == 16'd0) begin
        if (pad_left != 8'd0) sphase = PH_PADDING;
        else last = 1'b1;
      end
    end else begin
      cls = CLS_PAD;
      if (pad_left != 8'd0) pad_left = pad_left - 8'd1;
      if (pad_left == 8'd0) last = 1'b1;
    end
    r.byte_value = b;
    r.byte_class = cls;
    r.record_kind = kind;
    r.record_id = rec_id;
    r.event_code = ev;
    r.name_length = nlen;
    r.value_length = vlen;
    r.pair_index = pairs;
    r.bad_version = (ver != VERSION_1);
    r.record_last = last;
    if (last) begin
      sphase = PH_HEADER;
      hdr_pos = 3'd0;
      if (kind == KIND_ABORT) begin
        closed = 1'b1;
        sphase = PH_CLOSED;
      end
    end
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("val=%h cls=%0d kind=%h id=%h ev=%0d nlen=%0d vlen=%0d pairs=%0d bad=%b last=%b",
                     r.byte_value, r.byte_class, r.record_kind, r.record_id, r.event_code,
                     r.name_length, r.value_length, r.pair_index, r.bad_version, r.record_last);
  endfunction

  task automatic add_junk(input int n);
    repeat (n) body.push_back(8'($urandom_range(0, 255)));
  endtask

  // short form up to 127 unless wide is set, otherwise four bytes with the top bit set
  task automatic add_len(input logic [30:0] n, input bit wide);
    if (wide || n > 31'd127) begin
      body.push_back({1'b1, n[30:24]});
      body.push_back(n[23:16]);
      body.push_back(n[15:8]);
      body.push_back(n[7:0]);
    end else begin
      body.push_back(n[7:0]);
    end
  endtask

  task automatic add_pair(input int nl, input int vl, input bit wide);
    add_len(31'(nl), wide && ($urandom_range(0, 1) == 0));
    add_len(31'(vl), wide && ($urandom_range(0, 1) == 0));
    add_junk(nl + vl);
  endtask

  task automatic send_record(input logic [7:0] v, input logic [7:0] k, input logic [15:0] id,
                             input logic [7:0] plen);
    logic [15:0] clen;
    clen = 16'(body.size());
    stream_bytes.push_back(v);
    stream_bytes.push_back(k);
    stream_bytes.push_back(id[15:8]);
    stream_bytes.push_back(id[7:0]);
    stream_bytes.push_back(clen[15:8]);
    stream_bytes.push_back(clen[7:0]);
    stream_bytes.push_back(plen);
    stream_bytes.push_back(8'($urandom_range(0, 255)));
    foreach (body[i]) stream_bytes.push_back(body[i]);
    repeat (plen) stream_bytes.push_back(8'($urandom_range(0, 255)));
    body.delete();
  endtask

  // byte source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= 8'd0;
    end else begin
      if (s_valid && s_ready) begin
        parse_results.push_back(parse_stream_byte(s_data));
        sent_count++;
      end
      if (!s_valid || s_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_valid <= 1'b0;
        end else if (stream_bytes.size() == 0) begin
          s_valid <= 1'b0;
        end else if (sent_count < calm_from && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 15);
          s_valid <= 1'b0;
        end else begin
          s_valid <= 1'b1;
          s_data <= stream_bytes.pop_front();
        end
      end
    end
  end

  // verdict sink and checker
  always @(posedge clk_i or negedge rst_ni) begin : sink
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        seen = '0;
        seen.byte_value = m_data[7:0];
        seen.record_kind = m_data[15:8];
        seen.record_id = m_data[31:16];
        seen.event_code = m_data[35:32];
        seen.name_length = m_data[66:36];
        seen.value_length = m_data[97:67];
        seen.pair_index = m_data[113:98];
        seen.bad_version = m_data[114];
        seen.byte_class = m_user;
        seen.record_last = m_last;
        if (parse_results.size() == 0) begin
          if (fail_count < 10)
            $display("result %0d with nothing outstanding: %s", rx_count, show(seen));
          fail_count++;
        end else begin
          want = parse_results.pop_front();
          if (seen !== want) begin
            if (fail_count < 10)
              $display("mismatch on result %0d\n  expected %s\n  actual   %s",
                       rx_count, show(want), show(seen));
            fail_count++;
          end
        end
        rx_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (!pressure_done && rx_count >= HOLD_AFTER) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_ready <= 1'b0;
      end else if (rx_count < calm_from && $urandom_range(0, 15) == 0) begin
        hold_left = $urandom_range(0, 15);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int directed_end;
    int pick;
    int nl;
    int vl;
    logic [7:0] v;
    logic [7:0] k;
    logic [7:0] plen;

    // params and a short begin before any request
    add_pair(1, 1, 1'b0);
    send_record(VERSION_1, KIND_PARAMS, 16'h0001, 8'd0);
    add_junk(5);
    send_record(VERSION_1, KIND_BEGIN, 16'h0000, 8'd2);
    add_junk(8);
    send_record(VERSION_1, KIND_BEGIN, SESSION_ID, 8'd0);
    // id mismatch
    add_pair(2, 3, 1'b0);
    send_record(VERSION_1, KIND_PARAMS, 16'hffff, 8'd1);
    // well-formed pairs, short and long lengths, empty pair, value only
    add_pair(3, 5, 1'b0);
    add_pair(0, 0, 1'b0);
    add_len(31'd2, 1'b1);
    add_len(31'd1, 1'b0);
    add_junk(3);
    add_pair(0, 2, 1'b0);
    add_pair(1, 0, 1'b1);
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd3);
    // oversized pair
    add_len(31'd4, 1'b0);
    add_len(31'd100, 1'b0);
    add_junk(6);
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd0);
    // long length with too few bytes left
    body.push_back(8'h05);
    body.push_back(8'h80);
    body.push_back(8'h01);
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd0);
    // long name length that uses up the content, then a lone short one
    add_len(31'd0, 1'b1);
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd1);
    body.push_back(8'h03);
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd0);
    // largest lengths
    add_len(31'h7fffffff, 1'b1);
    add_len(31'd127, 1'b0);
    add_junk(2);
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd0);
    // empty params, with and without padding
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd0);
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd4);
    // stdin with widest padding
    add_junk(10);
    send_record(VERSION_1, KIND_STDIN, SESSION_ID, 8'd255);
    // unknown kinds
    add_junk(3);
    send_record(VERSION_1, 8'd0, 16'h1234, 8'd0);
    send_record(VERSION_1, 8'd255, 16'hffff, 8'd2);
    add_junk(1);
    send_record(VERSION_1, UNKNOWN_KIND, 16'h0000, 8'd0);
    // wrong versions are only flagged
    add_junk(4);
    send_record(8'd0, KIND_STDIN, SESSION_ID, 8'd0);
    add_pair(2, 2, 1'b0);
    send_record(8'hff, KIND_PARAMS, SESSION_ID, 8'd1);
    // second begin once a request is open
    add_junk(8);
    send_record(VERSION_1, KIND_BEGIN, SESSION_ID, 8'd0);

    directed_end = stream_bytes.size();
    while (stream_bytes.size() < directed_end + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      v = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : VERSION_1;
      plen = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 7));
      if (pick < 50) begin
        repeat ($urandom_range(1, 4))
          add_pair($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 3) == 0);
        case ($urandom_range(0, 7))
          0: begin
            nl = $urandom_range(1, 6);
            vl = $urandom_range(1, 6);
            add_len(31'(nl), $urandom_range(0, 1) == 0);
            add_len(31'(vl), $urandom_range(0, 1) == 0);
            add_junk($urandom_range(0, nl + vl - 1));
          end
          1: begin
            body.push_back(8'h80 | 8'($urandom_range(0, 255)));
            add_junk($urandom_range(0, 2));
          end
          2: add_len(31'($urandom_range(0, 127)), 1'b0);
          default: ;
        endcase
        send_record(v, KIND_PARAMS, SESSION_ID, plen);
      end else if (pick < 60) begin
        send_record(v, KIND_PARAMS, SESSION_ID, plen);
      end else if (pick < 70) begin
        add_junk($urandom_range(0, 12));
        send_record(v, KIND_STDIN, 16'($urandom_range(0, 65535)), plen);
      end else if (pick < 78) begin
        add_pair($urandom_range(0, 4), $urandom_range(0, 4), 1'b0);
        send_record(v, KIND_PARAMS, SESSION_ID ^ 16'($urandom_range(1, 65535)), plen);
      end else if (pick < 85) begin
        k = 8'($urandom_range(0, 255));
        if (k == KIND_BEGIN || k == KIND_ABORT || k == KIND_PARAMS || k == KIND_STDIN)
          k = UNKNOWN_KIND;
        add_junk($urandom_range(0, 10));
        send_record(v, k, 16'($urandom_range(0, 65535)), plen);
      end else if (pick < 90) begin
        add_junk(($urandom_range(0, 1) == 0) ? 8 : $urandom_range(0, 12));
        send_record(v, KIND_BEGIN, 16'($urandom_range(0, 65535)), plen);
      end else begin
        // garbage content, mostly as params of the open request
        k = ($urandom_range(0, 1) == 0) ? KIND_PARAMS : 8'($urandom_range(0, 255));
        if (k == KIND_ABORT) k = UNKNOWN_KIND;
        add_junk($urandom_range(0, 15));
        send_record(v, k, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : SESSION_ID,
                    plen);
      end
    end
    calm_from = stream_bytes.size() - 100;

    repeat (2) add_pair(0, 0, 1'b0);
    add_pair(1, 1, 1'b0);
    send_record(VERSION_1, KIND_PARAMS, SESSION_ID, 8'd0);
    // abort closes the connection for good
    add_junk(3);
    send_record(VERSION_1, KIND_ABORT, SESSION_ID, 8'd2);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hff);
    repeat (20) stream_bytes.push_back(8'($urandom_range(0, 255)));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (stream_bytes.size() != 0 || s_valid) @(posedge clk_i);
    while (parse_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
